@@ rtl/core/mer_pkg.sv @@
// Shared widths, types, sequencer codes and control structs of the midpoint ellipse rasterizer.
package mer_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;
    localparam int OUT_BITS    = COORD_BITS + 2;
    localparam int OFF_BITS    = RADIUS_BITS + 1;
    localparam int T_BITS      = OFF_BITS + 1;
    localparam int SQ_BITS     = 2 * RADIUS_BITS;
    localparam int MA_BITS     = SQ_BITS;
    localparam int MB_BITS     = 2 * T_BITS;
    localparam int DEC_BITS    = MA_BITS + MB_BITS;
    localparam int CS_BITS     = ((COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS) + 2;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef logic [COORD_BITS-1:0]         t_coord;
    typedef logic [RADIUS_BITS-1:0]        t_rad;
    typedef logic [OFF_BITS-1:0]           t_off;
    typedef logic [T_BITS-1:0]             t_tval;
    typedef logic [SQ_BITS-1:0]            t_sq;
    typedef logic [MA_BITS-1:0]            t_ma;
    typedef logic [MB_BITS-1:0]            t_mb;
    typedef logic [DEC_BITS-1:0]           t_dec;
    typedef logic signed [CS_BITS-1:0]     t_cs;
    typedef logic signed [OUT_BITS-1:0]    t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S0, ST_S1, ST_S2, ST_S3,
        ST_A0, ST_A1, ST_A2,
        ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5
    } t_state;

    typedef enum logic [2:0] {
        A_RX, A_RY, A_RX2, A_RY2, A_T, A_YM1
    } t_asel;

    typedef enum logic [3:0] {
        B_RX, B_RY, B_X, B_Y, B_T, B_YM1, B_TMP1, B_TMP2, B_RY2
    } t_bsel;

    typedef enum logic [2:0] {
        C_NONE, C_RX2, C_RY2, C_TMP1, C_TMP2
    } t_cap;

    typedef enum logic [2:0] {
        D_HOLD, D_START, D_STEP1, D_STEP2, D_LOAD, D_ADD4, D_SUB4
    } t_dop;

    typedef struct packed {
        logic accept;
        logic start;
        logic step;
        logic to_r2;
    } t_stat;

    typedef struct packed {
        logic  idle;
        t_asel a_sel;
        t_bsel b_sel;
        t_cap  cap;
        t_dop  d_op;
        logic  set_r2;
    } t_ctrl;

endpackage

@@ rtl/core/midpoint_ellipse_rasterizer_unit.sv @@
// Top level of the midpoint ellipse rasterizer: datapath, output register and sequencer.
//
// Input channel (i_valid / o_stall) carries a command: 0 starts an ellipse from
// centre and radii, 1 advances one point set. Every transfer in yields exactly one
// transfer out (o_valid / i_stall). A start or an advance while idle gives an
// all-zero result; an active advance gives the four mirrored points of the
// current offset and flags the final set with o_last_point.
// The result is in the output register in the cycle after the input transfer.
// The next input is taken once the sequencer is idle:
//   start: three products on the shared multiplier, then the decision,
//   advance: two products and a two-part decision update,
//   advance that crosses into region 2: five more products,
//   advance on the final set or while idle: the sequencer stays idle.
// All of these products go through the one shared multiplier.
// A stalled result holds; a new input is taken in the cycle the result leaves.
// Reset (synchronous, active low) empties the output register and goes idle.
module midpoint_ellipse_rasterizer_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_command,
    input  mer_pkg::t_coord       i_centre_x,
    input  mer_pkg::t_coord       i_centre_y,
    input  mer_pkg::t_rad         i_radius_x,
    input  mer_pkg::t_rad         i_radius_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_point_valid,
    output mer_pkg::t_out         o_col_right,
    output mer_pkg::t_out         o_col_left,
    output mer_pkg::t_out         o_row_below,
    output mer_pkg::t_out         o_row_above,
    output logic                  o_last_point
);

    mer_pkg::t_ctrl  ctrl;
    mer_pkg::t_stat  stat;
    mer_pkg::t_ma    mul_a;
    mer_pkg::t_mb    mul_b;
    mer_pkg::t_dec   prod;

    logic            r_active;
    logic            r_ovalid;
    logic            r_r2;
    logic            r_xinc;
    logic            r_ydec;
    mer_pkg::t_coord r_cx;
    mer_pkg::t_coord r_cy;
    mer_pkg::t_rad   r_rx;
    mer_pkg::t_rad   r_ry;
    mer_pkg::t_sq    r_rx2;
    mer_pkg::t_sq    r_ry2;
    mer_pkg::t_off   r_x;
    mer_pkg::t_rad   r_y;
    mer_pkg::t_dec   r_dec;
    mer_pkg::t_dec   r_tmp1;
    mer_pkg::t_mb    r_tmp2;

    logic            r_point_valid;
    mer_pkg::t_out   r_col_right;
    mer_pkg::t_out   r_col_left;
    mer_pkg::t_out   r_row_below;
    mer_pkg::t_out   r_row_above;
    logic            r_last_point;

    logic            ready;
    logic            in_acc;
    logic            is_start;
    logic            dec_neg;
    logic            dec_pos;
    logic            xinc_now;
    logic            ydec_now;
    logic            last_now;
    mer_pkg::t_tval  t_val;
    mer_pkg::t_rad   ym1;
    mer_pkg::t_dec   p4;
    mer_pkg::t_dec   p8;
    mer_pkg::t_dec   rx2_4;
    mer_pkg::t_dec   ry2_4;
    mer_pkg::t_cs    cx_w;
    mer_pkg::t_cs    cy_w;
    mer_pkg::t_cs    x_w;
    mer_pkg::t_cs    y_w;

    assign ready    = ctrl.idle && (!r_ovalid || !i_stall);
    assign o_stall  = !ready;
    assign in_acc   = i_valid && ready;
    assign is_start = (i_command == mer_pkg::CMD_START);

    assign dec_neg  = r_dec[mer_pkg::DEC_BITS-1];
    assign dec_pos  = !dec_neg && (r_dec != '0);
    assign xinc_now = !r_r2 || !dec_pos;
    assign ydec_now = r_r2 || !dec_neg;
    assign last_now = ydec_now && (r_y == '0);

    assign t_val = {r_x, 1'b1};
    assign ym1   = (r_y == '0) ? mer_pkg::t_rad'(1) : (r_y - mer_pkg::t_rad'(1));

    assign p4    = {prod[mer_pkg::DEC_BITS-3:0], 2'b00};
    assign p8    = {prod[mer_pkg::DEC_BITS-4:0], 3'b000};
    assign rx2_4 = {mer_pkg::t_dec'(r_rx2)} << 2;
    assign ry2_4 = {mer_pkg::t_dec'(r_ry2)} << 2;

    assign cx_w = mer_pkg::t_cs'(r_cx);
    assign cy_w = mer_pkg::t_cs'(r_cy);
    assign x_w  = mer_pkg::t_cs'(r_x);
    assign y_w  = mer_pkg::t_cs'(r_y);

    assign stat.accept = in_acc;
    assign stat.start  = is_start;
    assign stat.step   = r_active && !last_now;
    assign stat.to_r2  = !r_r2 && (r_tmp1 > prod);

    mer_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    mer_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        unique case (ctrl.a_sel)
            mer_pkg::A_RX:  mul_a = mer_pkg::t_ma'(r_rx);
            mer_pkg::A_RY:  mul_a = mer_pkg::t_ma'(r_ry);
            mer_pkg::A_RX2: mul_a = mer_pkg::t_ma'(r_rx2);
            mer_pkg::A_RY2: mul_a = mer_pkg::t_ma'(r_ry2);
            mer_pkg::A_T:   mul_a = mer_pkg::t_ma'(t_val);
            mer_pkg::A_YM1: mul_a = mer_pkg::t_ma'(ym1);
            default:        mul_a = '0;
        endcase
        unique case (ctrl.b_sel)
            mer_pkg::B_RX:   mul_b = mer_pkg::t_mb'(r_rx);
            mer_pkg::B_RY:   mul_b = mer_pkg::t_mb'(r_ry);
            mer_pkg::B_X:    mul_b = mer_pkg::t_mb'(r_x);
            mer_pkg::B_Y:    mul_b = mer_pkg::t_mb'(r_y);
            mer_pkg::B_T:    mul_b = mer_pkg::t_mb'(t_val);
            mer_pkg::B_YM1:  mul_b = mer_pkg::t_mb'(ym1);
            mer_pkg::B_TMP1: mul_b = r_tmp1[mer_pkg::MB_BITS-1:0];
            mer_pkg::B_TMP2: mul_b = r_tmp2;
            mer_pkg::B_RY2:  mul_b = mer_pkg::t_mb'(r_ry2);
            default:         mul_b = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (in_acc) begin
                if (is_start) begin
                    r_active <= 1'b1;
                end else if (r_active && last_now) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // output payload and per-point stepping at the input transfer
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (is_start) begin
                r_point_valid <= 1'b0;
                r_col_right   <= '0;
                r_col_left    <= '0;
                r_row_below   <= '0;
                r_row_above   <= '0;
                r_last_point  <= 1'b0;
                r_cx          <= i_centre_x;
                r_cy          <= i_centre_y;
                r_rx          <= i_radius_x;
                r_ry          <= i_radius_y;
                r_x           <= '0;
                r_y           <= i_radius_y;
            end else if (r_active) begin
                r_point_valid <= 1'b1;
                r_col_right   <= mer_pkg::t_out'(cx_w + x_w);
                r_col_left    <= mer_pkg::t_out'(cx_w - x_w);
                r_row_below   <= mer_pkg::t_out'(cy_w + y_w);
                r_row_above   <= mer_pkg::t_out'(cy_w - y_w);
                r_last_point  <= last_now;
                r_xinc        <= xinc_now;
                r_ydec        <= ydec_now;
                r_x           <= r_x + mer_pkg::t_off'(xinc_now);
                if (ydec_now && (r_y != '0)) begin
                    r_y <= r_y - mer_pkg::t_rad'(1);
                end
            end else begin
                r_point_valid <= 1'b0;
                r_col_right   <= '0;
                r_col_left    <= '0;
                r_row_below   <= '0;
                r_row_above   <= '0;
                r_last_point  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_start) begin
            r_r2 <= 1'b0;
        end else if (ctrl.set_r2) begin
            r_r2 <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (ctrl.cap)
            mer_pkg::C_NONE: ;
            mer_pkg::C_RX2:  r_rx2  <= prod[mer_pkg::SQ_BITS-1:0];
            mer_pkg::C_RY2:  r_ry2  <= prod[mer_pkg::SQ_BITS-1:0];
            mer_pkg::C_TMP1: r_tmp1 <= prod;
            mer_pkg::C_TMP2: r_tmp2 <= prod[mer_pkg::MB_BITS-1:0];
            default: ;
        endcase
    end

    // decision kept at four times the textbook value, wrapping in DEC_BITS
    always_ff @(posedge i_clk) begin
        unique case (ctrl.d_op)
            mer_pkg::D_HOLD:  ;
            mer_pkg::D_START: r_dec <= ry2_4 - p4 + mer_pkg::t_dec'(r_rx2);
            mer_pkg::D_STEP1: r_dec <= r_dec + (r_xinc ? p8 : '0) + (r_r2 ? rx2_4 : ry2_4);
            mer_pkg::D_STEP2: r_dec <= r_dec - (r_ydec ? p8 : '0);
            mer_pkg::D_LOAD:  r_dec <= prod;
            mer_pkg::D_ADD4:  r_dec <= r_dec + p4;
            mer_pkg::D_SUB4:  r_dec <= r_dec - p4;
            default: ;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_point_valid = r_point_valid;
    assign o_col_right   = r_col_right;
    assign o_col_left    = r_col_left;
    assign o_row_below   = r_row_below;
    assign o_row_above   = r_row_above;
    assign o_last_point  = r_last_point;

endmodule

@@ rtl/core/mer_mult.sv @@
// Shared unsigned multiplier with a registered product.
module mer_mult (
    input  logic           i_clk,
    input  mer_pkg::t_ma   i_a,
    input  mer_pkg::t_mb   i_b,
    output mer_pkg::t_dec  o_prod
);

    mer_pkg::t_dec r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= mer_pkg::t_dec'(i_a) * mer_pkg::t_dec'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/core/mer_ctrl.sv @@
// Sequencer that schedules the shared multiplier and the decision updates.
module mer_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mer_pkg::t_stat  i_stat,
    output mer_pkg::t_ctrl  o_ctrl
);

    mer_pkg::t_state r_state;
    mer_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mer_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ctrl.idle   = 1'b0;
        o_ctrl.a_sel  = mer_pkg::A_RX;
        o_ctrl.b_sel  = mer_pkg::B_RX;
        o_ctrl.cap    = mer_pkg::C_NONE;
        o_ctrl.d_op   = mer_pkg::D_HOLD;
        o_ctrl.set_r2 = 1'b0;
        unique case (r_state)
            mer_pkg::ST_IDLE: begin
                o_ctrl.idle = 1'b1;
                if (i_stat.accept) begin
                    if (i_stat.start) begin
                        n_state = mer_pkg::ST_S0;
                    end else if (i_stat.step) begin
                        n_state = mer_pkg::ST_A0;
                    end
                end
            end
            mer_pkg::ST_S0: begin
                o_ctrl.a_sel = mer_pkg::A_RX;
                o_ctrl.b_sel = mer_pkg::B_RX;
                n_state      = mer_pkg::ST_S1;
            end
            mer_pkg::ST_S1: begin
                o_ctrl.a_sel = mer_pkg::A_RY;
                o_ctrl.b_sel = mer_pkg::B_RY;
                o_ctrl.cap   = mer_pkg::C_RX2;
                n_state      = mer_pkg::ST_S2;
            end
            mer_pkg::ST_S2: begin
                o_ctrl.a_sel = mer_pkg::A_RX2;
                o_ctrl.b_sel = mer_pkg::B_RY;
                o_ctrl.cap   = mer_pkg::C_RY2;
                n_state      = mer_pkg::ST_S3;
            end
            mer_pkg::ST_S3: begin
                o_ctrl.d_op = mer_pkg::D_START;
                n_state     = mer_pkg::ST_IDLE;
            end
            mer_pkg::ST_A0: begin
                o_ctrl.a_sel = mer_pkg::A_RY2;
                o_ctrl.b_sel = mer_pkg::B_X;
                n_state      = mer_pkg::ST_A1;
            end
            mer_pkg::ST_A1: begin
                o_ctrl.a_sel = mer_pkg::A_RX2;
                o_ctrl.b_sel = mer_pkg::B_Y;
                o_ctrl.cap   = mer_pkg::C_TMP1;
                o_ctrl.d_op  = mer_pkg::D_STEP1;
                n_state      = mer_pkg::ST_A2;
            end
            mer_pkg::ST_A2: begin
                o_ctrl.d_op = mer_pkg::D_STEP2;
                n_state     = i_stat.to_r2 ? mer_pkg::ST_R0 : mer_pkg::ST_IDLE;
            end
            mer_pkg::ST_R0: begin
                o_ctrl.a_sel = mer_pkg::A_T;
                o_ctrl.b_sel = mer_pkg::B_T;
                n_state      = mer_pkg::ST_R1;
            end
            mer_pkg::ST_R1: begin
                o_ctrl.a_sel = mer_pkg::A_YM1;
                o_ctrl.b_sel = mer_pkg::B_YM1;
                o_ctrl.cap   = mer_pkg::C_TMP1;
                n_state      = mer_pkg::ST_R2;
            end
            mer_pkg::ST_R2: begin
                o_ctrl.a_sel = mer_pkg::A_RY2;
                o_ctrl.b_sel = mer_pkg::B_TMP1;
                o_ctrl.cap   = mer_pkg::C_TMP2;
                n_state      = mer_pkg::ST_R3;
            end
            mer_pkg::ST_R3: begin
                o_ctrl.a_sel = mer_pkg::A_RX2;
                o_ctrl.b_sel = mer_pkg::B_TMP2;
                o_ctrl.d_op  = mer_pkg::D_LOAD;
                n_state      = mer_pkg::ST_R4;
            end
            mer_pkg::ST_R4: begin
                o_ctrl.a_sel = mer_pkg::A_RX2;
                o_ctrl.b_sel = mer_pkg::B_RY2;
                o_ctrl.d_op  = mer_pkg::D_ADD4;
                n_state      = mer_pkg::ST_R5;
            end
            mer_pkg::ST_R5: begin
                o_ctrl.d_op   = mer_pkg::D_SUB4;
                o_ctrl.set_r2 = 1'b1;
                n_state       = mer_pkg::ST_IDLE;
            end
            default: begin
                n_state = mer_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the midpoint ellipse rasterizer: directed table, random ellipses.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   NUM_ROWS    = 24;
    localparam int   PHASE_ITEMS = 500;
    localparam int   HOLD_CYCLES = 400;
    localparam int   STUCK_LIMIT = 5000;

    typedef struct packed {
        logic            cmd;
        mer_pkg::t_coord cx;
        mer_pkg::t_coord cy;
        mer_pkg::t_rad   rx;
        mer_pkg::t_rad   ry;
    } t_cmd_item;

    typedef struct packed {
        logic          pv;
        mer_pkg::t_out cr;
        mer_pkg::t_out cl;
        mer_pkg::t_out rb;
        mer_pkg::t_out ra;
        logic          last;
    } t_point_set;

    typedef struct packed {
        t_cmd_item  it;
        logic       typed;
        t_point_set want;
    } t_row;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            i_valid    = 1'b0;
    logic            i_command  = 1'b0;
    mer_pkg::t_coord i_centre_x = '0;
    mer_pkg::t_coord i_centre_y = '0;
    mer_pkg::t_rad   i_radius_x = '0;
    mer_pkg::t_rad   i_radius_y = '0;
    logic            i_stall    = 1'b0;
    logic            o_stall;
    logic            o_valid;
    logic            o_point_valid;
    mer_pkg::t_out   o_col_right;
    mer_pkg::t_out   o_col_left;
    mer_pkg::t_out   o_row_below;
    mer_pkg::t_out   o_row_above;
    logic            o_last_point;

    midpoint_ellipse_rasterizer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_centre_x    (i_centre_x),
        .i_centre_y    (i_centre_y),
        .i_radius_x    (i_radius_x),
        .i_radius_y    (i_radius_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_point_valid (o_point_valid),
        .o_col_right   (o_col_right),
        .o_col_left    (o_col_left),
        .o_row_below   (o_row_below),
        .o_row_above   (o_row_above),
        .o_last_point  (o_last_point)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // tracked ellipse state
    logic [63:0]     trk_x;
    longint          trk_y;
    logic [63:0]     trk_dec;
    bit              trk_r2;
    bit              trk_busy;
    mer_pkg::t_coord trk_col;
    mer_pkg::t_coord trk_row;
    logic [63:0]     trk_rx2;
    logic [63:0]     trk_ry2;

    t_point_set pending_points[$];
    int         errors       = 0;
    int         items_sent   = 0;
    int         snd_idle_pct = 0;
    int         rcv_stall_pct = 0;
    bit         hold_req     = 1'b0;
    int         hold_cnt     = 0;
    int         stuck_cycles = 0;
    t_row       dir_rows[NUM_ROWS];

    function automatic t_point_set ellipse_step(input t_cmd_item it);
        t_point_set  res;
        logic [63:0] rx;
        logic [63:0] ry;
        logic [63:0] t;
        logic [63:0] ym1;
        longint      c_col;
        longint      c_row;
        bit          pos;
        res = '0;
        if (it.cmd == mer_pkg::CMD_START) begin
            rx = 64'(it.rx);
            ry = 64'(it.ry);
            trk_col  = it.cx;
            trk_row  = it.cy;
            trk_rx2  = rx * rx;
            trk_ry2  = ry * ry;
            trk_x    = '0;
            trk_y    = longint'(ry);
            trk_r2   = 1'b0;
            trk_busy = 1'b1;
            trk_dec  = 64'd4 * trk_ry2 - 64'd4 * trk_rx2 * ry + trk_rx2;
            return res;
        end
        if (!trk_busy) return res;
        c_col = longint'(trk_col);
        c_row = longint'(trk_row);
        res.pv = 1'b1;
        res.cr = mer_pkg::t_out'(c_col + longint'(trk_x));
        res.cl = mer_pkg::t_out'(c_col - longint'(trk_x));
        res.rb = mer_pkg::t_out'(c_row + trk_y);
        res.ra = mer_pkg::t_out'(c_row - trk_y);
        if (!trk_r2) begin
            trk_x = trk_x + 64'd1;
            if (trk_dec[63]) begin
                trk_dec = trk_dec + 64'd8 * trk_ry2 * trk_x + 64'd4 * trk_ry2;
            end else begin
                trk_y = trk_y - 1;
                trk_dec = trk_dec + 64'd8 * trk_ry2 * trk_x + 64'd4 * trk_ry2
                        - 64'd8 * trk_rx2 * 64'(trk_y);
            end
        end else begin
            pos = !trk_dec[63] && (trk_dec != 64'd0);
            trk_y = trk_y - 1;
            if (pos) begin
                trk_dec = trk_dec + 64'd4 * trk_rx2 - 64'd8 * trk_rx2 * 64'(trk_y);
            end else begin
                trk_x = trk_x + 64'd1;
                trk_dec = trk_dec + 64'd8 * trk_ry2 * trk_x + 64'd4 * trk_rx2
                        - 64'd8 * trk_rx2 * 64'(trk_y);
            end
        end
        if (trk_y < 0) begin
            res.last = 1'b1;
            trk_busy = 1'b0;
            trk_y    = 0;
            return res;
        end
        if (!trk_r2 && (trk_ry2 * trk_x > trk_rx2 * 64'(trk_y))) begin
            t   = 64'd2 * trk_x + 64'd1;
            ym1 = 64'(trk_y - 1);
            trk_r2  = 1'b1;
            trk_dec = trk_ry2 * t * t + 64'd4 * trk_rx2 * ym1 * ym1
                    - 64'd4 * trk_rx2 * trk_ry2;
        end
        return res;
    endfunction

    function automatic t_cmd_item make_item(input logic cmd, input int cx, input int cy,
                                            input int rx, input int ry);
        t_cmd_item it;
        it.cmd = cmd;
        it.cx  = mer_pkg::t_coord'(cx);
        it.cy  = mer_pkg::t_coord'(cy);
        it.rx  = mer_pkg::t_rad'(rx);
        it.ry  = mer_pkg::t_rad'(ry);
        return it;
    endfunction

    function automatic t_row make_row(input t_cmd_item it, input logic typed,
                                      input logic pv, input int cr, input int cl,
                                      input int rb, input int ra, input logic last);
        t_row r;
        r.it      = it;
        r.typed   = typed;
        r.want.pv = pv;
        r.want.cr = mer_pkg::t_out'(cr);
        r.want.cl = mer_pkg::t_out'(cl);
        r.want.rb = mer_pkg::t_out'(rb);
        r.want.ra = mer_pkg::t_out'(ra);
        r.want.last = last;
        return r;
    endfunction

    function automatic t_cmd_item rand_advance();
        return make_item(mer_pkg::CMD_ADVANCE, $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 2047),
                         $urandom_range(0, 2047));
    endfunction

    task automatic send_item(input t_cmd_item it, input bit typed, input t_point_set want);
        t_point_set pred;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= it.cmd;
        i_centre_x <= it.cx;
        i_centre_y <= it.cy;
        i_radius_x <= it.rx;
        i_radius_y <= it.ry;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (it.cmd == mer_pkg::CMD_START || trk_busy) items_sent++;
        pred = ellipse_step(it);
        pending_points.push_back(typed ? want : pred);
    endtask

    task automatic send_pred(input t_cmd_item it);
        send_item(it, 1'b0, '0);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_ellipse();
        int kind;
        int cap;
        int n;
        int rs;
        int rl;
        t_cmd_item it;
        kind = $urandom_range(99);
        cap  = 1000;
        if (kind < 65) begin
            it = make_item(mer_pkg::CMD_START, $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 20),
                           $urandom_range(0, 20));
        end else if (kind < 85) begin
            it = make_item(mer_pkg::CMD_START, $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 2047),
                           $urandom_range(0, 2047));
            cap = $urandom_range(1, 40);
        end else if (kind < 95) begin
            rs = $urandom_range(0, 7);
            rl = $urandom_range(0, 2047);
            if ($urandom_range(1))
                it = make_item(mer_pkg::CMD_START, $urandom_range(0, 4095),
                               $urandom_range(0, 4095), rs, rl);
            else
                it = make_item(mer_pkg::CMD_START, $urandom_range(0, 4095),
                               $urandom_range(0, 4095), rl, rs);
            cap = $urandom_range(20, 80);
        end else begin
            // noise: a lone item of either kind
            it = rand_advance();
            it.cmd = logic'($urandom_range(1));
            send_pred(it);
            return;
        end
        send_pred(it);
        n = 0;
        while (trk_busy && n < cap) begin
            send_pred(rand_advance());
            n++;
        end
        if (!trk_busy && $urandom_range(3) == 0) send_pred(rand_advance());
    endtask

    task automatic cmp_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // output side: check transfers, drive stall
    always @(posedge i_clk) begin
        t_point_set w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_points.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                w = pending_points.pop_front();
                cmp_field("point_valid", w.pv, o_point_valid);
                cmp_field("col_right", $signed(w.cr), $signed(o_col_right));
                cmp_field("col_left", $signed(w.cl), $signed(o_col_left));
                cmp_field("row_below", $signed(w.rb), $signed(o_row_below));
                cmp_field("row_above", $signed(w.ra), $signed(o_row_above));
                cmp_field("last_point", w.last, o_last_point);
            end
        end
        if (hold_req && hold_cnt == 0) begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("[midpoint_ellipse_rasterizer_unit] ERROR");
            $finish;
        end
    end

    initial begin
        dir_rows[0]  = make_row(make_item(mer_pkg::CMD_ADVANCE, 4095, 4095, 2047, 2047), 1,
                                0, 0, 0, 0, 0, 0);
        dir_rows[1]  = make_row(make_item(mer_pkg::CMD_START, 100, 200, 0, 0), 1,
                                0, 0, 0, 0, 0, 0);
        dir_rows[2]  = make_row(make_item(mer_pkg::CMD_ADVANCE, 0, 0, 0, 0), 1,
                                1, 100, 100, 200, 200, 1);
        dir_rows[3]  = make_row(make_item(mer_pkg::CMD_ADVANCE, 0, 0, 0, 0), 1,
                                0, 0, 0, 0, 0, 0);
        dir_rows[4]  = make_row(make_item(mer_pkg::CMD_START, 4095, 4095, 2047, 2047), 1,
                                0, 0, 0, 0, 0, 0);
        dir_rows[5]  = make_row(make_item(mer_pkg::CMD_ADVANCE, 0, 0, 0, 0), 1,
                                1, 4095, 4095, 6142, 2048, 0);
        dir_rows[6]  = make_row(make_item(mer_pkg::CMD_ADVANCE, 0, 0, 0, 0), 0,
                                0, 0, 0, 0, 0, 0);
        dir_rows[7]  = make_row(make_item(mer_pkg::CMD_ADVANCE, 4095, 4095, 2047, 2047), 0,
                                0, 0, 0, 0, 0, 0);
        dir_rows[8]  = make_row(make_item(mer_pkg::CMD_ADVANCE, 0, 0, 0, 0), 0,
                                0, 0, 0, 0, 0, 0);
        // restart while an ellipse is in progress
        dir_rows[9]  = make_row(make_item(mer_pkg::CMD_START, 0, 0, 2047, 2047), 1,
                                0, 0, 0, 0, 0, 0);
        dir_rows[10] = make_row(make_item(mer_pkg::CMD_ADVANCE, 0, 0, 0, 0), 1,
                                1, 0, 0, 2047, -2047, 0);
        dir_rows[11] = make_row(make_item(mer_pkg::CMD_ADVANCE, 0, 0, 0, 0), 0,
                                0, 0, 0, 0, 0, 0);
        // flat ellipse ends on its first set
        dir_rows[12] = make_row(make_item(mer_pkg::CMD_START, 50, 60, 5, 0), 1,
                                0, 0, 0, 0, 0, 0);
        dir_rows[13] = make_row(make_item(mer_pkg::CMD_ADVANCE, 0, 0, 0, 0), 1,
                                1, 50, 50, 60, 60, 1);
        // zero horizontal radius
        dir_rows[14] = make_row(make_item(mer_pkg::CMD_START, 2048, 1000, 0, 3), 1,
                                0, 0, 0, 0, 0, 0);
        for (int k = 15; k < 20; k++)
            dir_rows[k] = make_row(make_item(mer_pkg::CMD_ADVANCE, 0, 0, 0, 0), 0,
                                   0, 0, 0, 0, 0, 0);
        dir_rows[20] = make_row(make_item(mer_pkg::CMD_START, 4095, 0, 2047, 1), 1,
                                0, 0, 0, 0, 0, 0);
        for (int k = 21; k < NUM_ROWS; k++)
            dir_rows[k] = make_row(make_item(mer_pkg::CMD_ADVANCE, 0, 0, 0, 0), 0,
                                   0, 0, 0, 0, 0, 0);

        trk_x = '0; trk_y = 0; trk_dec = '0; trk_r2 = 1'b0; trk_busy = 1'b0;
        trk_col = '0; trk_row = '0; trk_rx2 = '0; trk_ry2 = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_ROWS; k++)
            send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 87; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 87; end
                default: begin snd_idle_pct = 15; rcv_stall_pct = 15; end
            endcase
            if (p == 0) hold_req = 1'b1;
            while (items_sent < NUM_ROWS + PHASE_ITEMS * (p + 1)) run_ellipse();
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_points.size() == 0)
            $display("[midpoint_ellipse_rasterizer_unit] OK");
        else
            $display("[midpoint_ellipse_rasterizer_unit] ERROR");
        $finish;
    end
endmodule
